@@ rtl/core/maximal_set_table_assert.svh @@
// assertion macros shared by the rtl
// each use expects clk and rst_n in scope and stands on a line of its own
`ifndef MAXIMAL_SET_TABLE_ASSERT_SVH
`define MAXIMAL_SET_TABLE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define MST_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MST_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mst_pkg.sv @@
`default_nettype none

package mst_pkg;

    // request codes carried in tuser
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam int REQ_W      = 2;
    localparam int CAND_W     = 32;
    localparam int SLOT_IDX_W = 6;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } state_t;

    // verdict on one stored entry against the candidate
    typedef struct packed {
        logic covered;
        logic remove;
        logic vacant;
    } cmp_t;

    // result fields, inserted in the lowest bit
    typedef struct packed {
        logic [CAND_W-1:0]  slot_mask;
        logic               slot_valid;
        logic [COUNT_W-1:0] live_count;
        logic [COUNT_W-1:0] removed_count;
        logic               overflow;
        logic               subsumed;
        logic               inserted;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

@@ rtl/core/mst_ram.sv @@
`default_nettype none

module mst_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/mst_cmp.sv @@
`default_nettype none

module mst_cmp
    import mst_pkg::*;
#(
    parameter int MASK_BITS = 32
) (
    input  wire logic                 entry_used,
    input  wire logic [MASK_BITS-1:0] entry_mask,
    input  wire logic [MASK_BITS-1:0] cand,
    output      cmp_t                 verdict
);

    logic cand_in_entry;
    logic entry_in_cand;

    assign cand_in_entry = ((cand & ~entry_mask) == '0);
    assign entry_in_cand = ((entry_mask & ~cand) == '0);

    // only a proper subset goes; an equal entry covers the candidate instead
    always_comb
    begin
        verdict.covered = entry_used && cand_in_entry;
        verdict.remove  = entry_used && entry_in_cand && !cand_in_entry;
        verdict.vacant  = !entry_used || verdict.remove;
    end

endmodule

`default_nettype wire

@@ rtl/core/maximal_set_table.sv @@
// maximal_set_table: keeps a table of attribute masks of which none is a
// subset of another
// input channel s_t*: one request per transaction, kind in s_tuser
// (insert, read slot, clear table); output channel m_t*: one result
// transaction per request, in request order
// the table sits in one simple dual port ram of TABLE_DEPTH entries,
// each a used flag and a mask; the controller reads an entry, judges it
// against the candidate as it comes back and writes a removed entry back cleared
// insert of a nonzero mask: the time from acceptance to result is set
// by the sweep of the single ram read port over all entries; a zero mask,
// a read or an unknown kind skips the sweep
// clear: one ram entry written per cycle over the whole table
// after reset the same clearing sweep runs with s_tready low
// one request is worked on at a time; s_tready is high only when idle
// the result sits in an output register, so the next request is taken
// while m_tvalid waits on m_tready; a stalled receiver holds a finished
// result in the controller until the output register frees up
`default_nettype none

`include "maximal_set_table_assert.svh"

module maximal_set_table
    import mst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int MASK_BITS   = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // candidate_mask [31:0], slot_index [37:32], zero fill above
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // req_type [1:0]
    input  wire logic [REQ_W-1:0]      s_tuser,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // inserted [0], subsumed [1], overflow [2], removed_count [9:3],
    // live_count [16:10], slot_valid [17], slot_mask [49:18], zero fill above
    output      logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = ((AW > SLOT_IDX_W) ? AW : SLOT_IDX_W) + 1;
    localparam int WW = (MASK_BITS > CAND_W) ? MASK_BITS : CAND_W;
    localparam int EW = MASK_BITS + 1;
    localparam int XW = LW + COUNT_W;

    // state and controller registers
    state_t               state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        prev_idx_reg, prev_idx_next;
    logic                 issue_reg, issue_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 clr_reply_reg, clr_reply_next;
    logic                 covered_reg, covered_next;
    logic                 free_found_reg, free_found_next;
    logic [AW-1:0]        free_idx_reg, free_idx_next;
    logic [COUNT_W-1:0]   removed_reg, removed_next;
    logic [LW-1:0]        live_reg, live_next;
    logic                 out_valid_reg, out_valid_next;

    // payload registers
    logic [MASK_BITS-1:0] cand_reg, cand_next;
    res_t                 res_reg, res_next;
    res_t                 out_reg, out_next;

    // request decode
    logic                 accept;
    logic [REQ_W-1:0]     req;
    logic [MASK_BITS-1:0] cand_in;
    logic                 cand_zero;
    logic [CW-1:0]        slot_ext;
    logic                 slot_in_range;
    logic [AW-1:0]        slot_addr;
    logic                 scan_last;
    logic                 out_free;

    // ram ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;
    cmp_t                 verdict;

    logic [WW-1:0]        rd_mask_ext;
    logic [XW-1:0]        live_ext;
    logic [COUNT_W-1:0]   live_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign req       = s_tuser;
    assign cand_in   = MASK_BITS'(WW'(s_tdata[CAND_W-1:0]));
    assign cand_zero = (cand_in == '0);

    // slot_index may be narrower or wider than the table address
    assign slot_ext      = CW'(s_tdata[CAND_W +: SLOT_IDX_W]);
    assign slot_in_range = (slot_ext < CW'(TABLE_DEPTH));
    assign slot_addr     = slot_ext[AW-1:0];

    assign scan_last = (idx_reg == AW'(TABLE_DEPTH - 1));
    assign out_free  = !out_valid_reg || m_tready;

    assign rd_mask_ext = WW'(ram_rdata[MASK_BITS-1:0]);

    assign live_ext = XW'(live_reg);
    assign live_sat = (live_ext > XW'(127)) ? COUNT_W'(127) : live_ext[COUNT_W-1:0];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

    mst_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // judges the entry read back in the previous cycle
    mst_cmp #(
        .MASK_BITS (MASK_BITS)
    ) u_cmp (
        .entry_used (ram_rdata[MASK_BITS]),
        .entry_mask (ram_rdata[MASK_BITS-1:0]),
        .cand       (cand_reg),
        .verdict    (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            prev_idx_reg   <= '0;
            issue_reg      <= 1'b0;
            rd_pend_reg    <= 1'b0;
            clr_reply_reg  <= 1'b0;
            covered_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            removed_reg    <= '0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            prev_idx_reg   <= prev_idx_next;
            issue_reg      <= issue_next;
            rd_pend_reg    <= rd_pend_next;
            clr_reply_reg  <= clr_reply_next;
            covered_reg    <= covered_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            removed_reg    <= removed_next;
            live_reg       <= live_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (scan_last)
                begin
                    state_next = clr_reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req)
                        REQ_INSERT: state_next = cand_zero ? ST_DONE : ST_SCAN;
                        REQ_READ:   state_next = slot_in_range ? ST_READ : ST_DONE;
                        REQ_CLEAR:  state_next = ST_CLEAR;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // last entry judged once the read pipe has drained
                if (!issue_reg && rd_pend_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        idx_next        = idx_reg;
        prev_idx_next   = prev_idx_reg;
        issue_next      = issue_reg;
        rd_pend_next    = 1'b0;
        clr_reply_next  = clr_reply_reg;
        covered_next    = covered_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        live_next       = live_reg;
        cand_next       = cand_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        ram_raddr       = idx_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // one entry zeroed per cycle
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                live_next = '0;
                idx_next  = scan_last ? '0 : idx_reg + AW'(1);
            end
            ST_IDLE:
            begin
                ram_raddr = slot_addr;
                if (accept)
                begin
                    res_next        = '0;
                    cand_next       = cand_in;
                    idx_next        = '0;
                    issue_next      = 1'b1;
                    covered_next    = 1'b0;
                    free_found_next = 1'b0;
                    removed_next    = '0;
                    clr_reply_next  = 1'b0;
                    case (req)
                        REQ_INSERT:
                        begin
                            // empty set never enters the table
                            res_next.subsumed = cand_zero;
                        end
                        REQ_CLEAR:  clr_reply_next = 1'b1;
                        default:    ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                ram_raddr     = idx_reg;
                rd_pend_next  = issue_reg;
                prev_idx_next = idx_reg;
                if (issue_reg)
                begin
                    idx_next   = scan_last ? '0 : idx_reg + AW'(1);
                    issue_next = !scan_last;
                end
                if (rd_pend_reg)
                begin
                    if (verdict.covered)
                    begin
                        covered_next = 1'b1;
                    end
                    if (verdict.remove)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = prev_idx_reg;
                        live_next = live_reg - LW'(1);
                        if (removed_reg != COUNT_W'(127))
                        begin
                            removed_next = removed_reg + COUNT_W'(1);
                        end
                    end
                    // lowest slot left free after removals
                    if (verdict.vacant && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = prev_idx_reg;
                    end
                end
            end
            ST_WRITE:
            begin
                res_next.removed_count = removed_reg;
                if (covered_reg)
                begin
                    res_next.subsumed = 1'b1;
                end
                else if (free_found_reg)
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = free_idx_reg;
                    ram_wdata         = {1'b1, cand_reg};
                    live_next         = live_reg + LW'(1);
                    res_next.inserted = 1'b1;
                end
                else
                begin
                    res_next.overflow = 1'b1;
                end
            end
            ST_READ:
            begin
                res_next.slot_valid = ram_rdata[MASK_BITS];
                res_next.slot_mask  = ram_rdata[MASK_BITS] ? rd_mask_ext[CAND_W-1:0] : '0;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next            = res_reg;
                    out_next.live_count = live_sat;
                    out_valid_next      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // the table never holds more entries than it has slots
    `MST_ASSERT_ALWAYS(a_live_bound, live_reg <= LW'(TABLE_DEPTH), "live count above depth")

    // a removal after a covering entry means the table lost its antichain property
    `MST_ASSERT_IMPLY(a_no_remove_when_covered,
        state_reg == ST_SCAN && rd_pend_reg && verdict.remove, !covered_reg,
        "subset removed although candidate covered")

    // overflow only with every slot live
    `MST_ASSERT_IMPLY(a_overflow_full,
        state_reg == ST_WRITE && !covered_reg && !free_found_reg,
        live_reg == LW'(TABLE_DEPTH), "overflow with free slot")

    // at most one insert verdict per result
    `MST_ASSERT_ALWAYS(a_one_verdict,
        !out_valid_reg || $countones({out_reg.inserted, out_reg.subsumed, out_reg.overflow}) <= 1,
        "conflicting insert flags")

    // a finished result is handed over only from the done state
    `MST_ASSERT_NEXT(a_load_from_done, !out_valid_reg && state_reg != ST_DONE, !out_valid_reg,
        "result appeared outside done state")

endmodule

`default_nettype wire
